@@ design/rdsm_pkg.sv @@
// Shared types and constants for the radial distortion sample map.
// Used by the top level, the square root pipeline and the divider pipeline.
package rdsm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_SIDE  = 4096;

  // Configuration port
  localparam int CFG_W     = 29;
  localparam int CFG_IDX_W = 3;
  localparam int SIDE_W    = 13;

  // Datapath widths
  localparam int PIX_W    = 12;
  localparam int DELTA_W  = 14;                 // signed offset from center
  localparam int ABS_W    = DELTA_W - 1;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int SUMSQ_W  = SQ_W + 1;
  localparam int ROOT_W   = 30;                 // radius in Q.16
  localparam int RAD_W    = 2 * ROOT_W;         // radicand, sum << 32
  localparam int SQREM_W  = ROOT_W + 2;
  localparam int R0_W     = 28;
  localparam int STR_W    = 24;
  localparam int NUM_W    = 56;
  localparam int MAG_W    = NUM_W - 1;
  localparam int F_W      = 42;
  localparam int COORD_W  = NUM_W - FRAC_BITS;
  localparam int INDEX_W  = 24;

  localparam logic [F_W-2:0] F_LIMIT = {1'b1, {(F_W-2){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_RADIUS        = 3'd2,
    REG_STRENGTH      = 3'd3,
    REG_SOURCE_WIDTH  = 3'd4,
    REG_SOURCE_HEIGHT = 3'd5,
    REG_SOURCE_PITCH  = 3'd6
  } cfg_reg_t;

  // Per-item values that ride alongside the square root
  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      last;
  } side_t;

  // Per-item values that ride alongside the divider
  typedef struct packed {
    side_t side;
    logic  neg;
  } div_side_t;

  // Clamp an image dimension to the largest supported side
  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
    return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
  endfunction

endpackage

@@ design/rdsm_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on rdsm_pkg; radicand is the sum of squares shifted up by 2*FRAC_BITS.
module rdsm_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [rdsm_pkg::SUMSQ_W-1:0]  sum_in,
  input  rdsm_pkg::side_t               side_in,
  output logic                          out_valid,
  output logic [rdsm_pkg::ROOT_W-1:0]   root_out,
  output rdsm_pkg::side_t               side_out
);
  import rdsm_pkg::*;

  localparam int STEPS = ROOT_W;

  logic               valid_q [0:STEPS];
  logic [SQREM_W-1:0] rem_q   [0:STEPS];
  logic [ROOT_W-1:0]  root_q  [0:STEPS];
  logic [RAD_W-1:0]   rad_q   [0:STEPS];
  side_t              side_q  [0:STEPS];

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= {{(RAD_W-SUMSQ_W-2*FRAC_BITS){1'b0}}, sum_in, {(2*FRAC_BITS){1'b0}}};
      side_q[0] <= side_in;
    end
  end

  // One digit pair per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [SQREM_W-1:0] rem_sh;
    logic [SQREM_W-1:0] trial;
    logic               ge;

    always_comb begin
      rem_sh = {rem_q[k][SQREM_W-3:0], rad_q[k][RAD_W-1 -: 2]};
      trial  = {root_q[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], ge};
        rad_q[k+1]  <= {rad_q[k][RAD_W-3:0], 2'b00};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = valid_q[STEPS];
  assign root_out  = root_q[STEPS];
  assign side_out  = side_q[STEPS];

endmodule

@@ design/rdsm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rdsm_pkg; divides the factor numerator magnitude by the radius.
module rdsm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rdsm_pkg::MAG_W-1:0]  mag_in,
  input  logic [rdsm_pkg::R0_W-1:0]   divisor,
  input  rdsm_pkg::div_side_t         side_in,
  output logic                        out_valid,
  output logic [rdsm_pkg::MAG_W-1:0]  quot_out,
  output rdsm_pkg::div_side_t         side_out
);
  import rdsm_pkg::*;

  localparam int STEPS = MAG_W;

  logic            valid_q [0:STEPS];
  logic [R0_W-1:0] rem_q   [0:STEPS];
  logic [MAG_W-1:0] qd_q   [0:STEPS];   // dividend bits shift out, quotient bits in
  div_side_t       side_q  [0:STEPS];

  // Entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= '0;
      qd_q[0]   <= mag_in;
      side_q[0] <= side_in;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [R0_W:0] trial;
    logic [R0_W:0] diff;
    logic          ge;

    always_comb begin
      trial = {rem_q[k], qd_q[k][MAG_W-1]};
      diff  = trial - {1'b0, divisor};
      ge    = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= ge ? diff[R0_W-1:0] : trial[R0_W-1:0];
        qd_q[k+1]   <= {qd_q[k][MAG_W-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = valid_q[STEPS];
  assign quot_out  = qd_q[STEPS];
  assign side_out  = side_q[STEPS];

endmodule

@@ design/radial_distortion_sample_map.sv @@
// Top level of the radial distortion sample map: maps destination pixels to source indexes.
// Depends on rdsm_pkg, rdsm_sqrt and rdsm_div.
//
// Throughput: one item per cycle while the skid register is empty; the square root
// (30 stages) and the divider (55 stages) are fully pipelined, one bit per stage.
// An output skid register takes one result while the output waits; the pipeline
// and the input then hold until it empties.
// Reset (rst, synchronous) empties the pipeline and loads the default registers.
module radial_distortion_sample_map (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdsm_pkg::CFG_W-1:0]      cfg_data,
  // destination pixels
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,   // pixel_x[11:0], pixel_y[23:12]
  input  logic                            s_tlast,   // span_end
  // source indexes
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // source_index[23:0]
  output logic                            m_tuser,   // inside_res
  output logic                            m_tlast    // span_end_out
);
  import rdsm_pkg::*;

  // Configuration registers
  logic signed [CFG_W-1:0]  center_x;
  logic signed [CFG_W-1:0]  center_y;
  logic        [R0_W-1:0]   radius;
  logic signed [STR_W-1:0]  strength;
  logic        [SIDE_W-1:0] source_width;
  logic        [SIDE_W-1:0] source_height;
  logic        [SIDE_W-1:0] source_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius        <= R0_W'(65536);
      strength      <= '0;
      source_width  <= SIDE_W'(MAX_SIDE);
      source_height <= SIDE_W'(MAX_SIDE);
      source_pitch  <= SIDE_W'(MAX_SIDE);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:      center_x <= cfg_data;
        REG_CENTER_Y:      center_y <= cfg_data;
        // a zero radius acts as the smallest nonzero one
        REG_RADIUS:        radius <= (cfg_data[R0_W-1:0] == '0) ? R0_W'(1) : cfg_data[R0_W-1:0];
        REG_STRENGTH:      strength <= cfg_data[STR_W-1:0];
        REG_SOURCE_WIDTH:  source_width <= sat_side(cfg_data[SIDE_W-1:0]);
        REG_SOURCE_HEIGHT: source_height <= sat_side(cfg_data[SIDE_W-1:0]);
        REG_SOURCE_PITCH:  source_pitch <= sat_side(cfg_data[SIDE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipeline moves unless the skid register is full
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // Offset from center in Q.16, truncated toward zero to whole pixels
  function automatic logic signed [DELTA_W-1:0] trunc_delta(input logic signed [30:0] v);
    logic [30:0] mag;
    logic [30:0] q;
    mag = v[30] ? 31'(-v) : 31'(v);
    q   = mag >> FRAC_BITS;
    return v[30] ? DELTA_W'(-$signed(q[DELTA_W-1:0])) : $signed(q[DELTA_W-1:0]);
  endfunction

  logic signed [30:0] offs_x;
  logic signed [30:0] offs_y;

  always_comb begin
    offs_x = $signed({3'b000, s_tdata[PIX_W-1:0], {FRAC_BITS{1'b0}}}) - 31'(center_x);
    offs_y = $signed({3'b000, s_tdata[2*PIX_W-1:PIX_W], {FRAC_BITS{1'b0}}}) - 31'(center_y);
  end

  // Stage A: offsets
  logic  va;
  side_t side_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a.dx   <= trunc_delta(offs_x);
      side_a.dy   <= trunc_delta(offs_y);
      side_a.last <= s_tlast;
    end
  end

  // Stage B: squares
  logic [ABS_W-1:0] abs_x;
  logic [ABS_W-1:0] abs_y;
  logic             vb;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_y;
  side_t            side_b;

  always_comb begin
    abs_x = side_a.dx[DELTA_W-1] ? ABS_W'(-side_a.dx) : ABS_W'(side_a.dx);
    abs_y = side_a.dy[DELTA_W-1] ? ABS_W'(-side_a.dy) : ABS_W'(side_a.dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x   <= abs_x * abs_x;
      sq_y   <= abs_y * abs_y;
      side_b <= side_a;
    end
  end

  // Radius from the sum of squares
  logic [SUMSQ_W-1:0] sum_sq;
  logic               vr;
  logic [ROOT_W-1:0]  root;
  side_t              side_r;

  assign sum_sq = {1'b0, sq_x} + {1'b0, sq_y};

  rdsm_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .sum_in    (sum_sq),
    .side_in   (side_b),
    .out_valid (vr),
    .root_out  (root),
    .side_out  (side_r)
  );

  // Stage D: strength * (r0 - r)
  logic signed [31:0]      rdiff;
  logic                    vd;
  logic signed [NUM_W-1:0] prod_d;
  logic [ROOT_W-1:0]       root_d;
  side_t                   side_d;

  assign rdiff = $signed({4'b0000, radius}) - $signed({2'b00, root});

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_d <= NUM_W'(strength) * NUM_W'(rdiff);
      root_d <= root;
      side_d <= side_r;
    end
  end

  // Stage E: numerator of the factor
  logic                    ve;
  logic signed [NUM_W-1:0] num_e;
  side_t                   side_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_e  <= prod_d + $signed({{(NUM_W-ROOT_W-FRAC_BITS){1'b0}}, root_d, {FRAC_BITS{1'b0}}});
      side_e <= side_d;
    end
  end

  // Magnitude into the divider, sign travels alongside
  logic [MAG_W-1:0] num_mag;
  div_side_t        dside_in;
  logic             vq;
  logic [MAG_W-1:0] quot;
  div_side_t        dside_out;

  always_comb begin
    num_mag       = num_e[NUM_W-1] ? MAG_W'(-num_e) : MAG_W'(num_e);
    dside_in.side = side_e;
    dside_in.neg  = num_e[NUM_W-1];
  end

  rdsm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ve),
    .mag_in    (num_mag),
    .divisor   (radius),
    .side_in   (dside_in),
    .out_valid (vq),
    .quot_out  (quot),
    .side_out  (dside_out)
  );

  // Stage G: saturate and sign the factor
  logic [F_W-2:0]        f_mag;
  logic                  vg;
  logic signed [F_W-1:0] f_g;
  side_t                 side_g;

  assign f_mag = (quot > MAG_W'(F_LIMIT)) ? F_LIMIT : quot[F_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_g    <= dside_out.neg ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
      side_g <= dside_out.side;
    end
  end

  // Stage H: factor times offset
  logic                    vh;
  logic signed [NUM_W-1:0] px_h;
  logic signed [NUM_W-1:0] py_h;
  logic                    last_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (en) begin
      vh <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_h   <= NUM_W'(f_g) * NUM_W'(side_g.dx);
      py_h   <= NUM_W'(f_g) * NUM_W'(side_g.dy);
      last_h <= side_g.last;
    end
  end

  // Stage I: add center back and floor to whole pixels
  logic signed [NUM_W-1:0] cx_sum;
  logic signed [NUM_W-1:0] cy_sum;
  logic                    vi;
  logic signed [COORD_W-1:0] sx_i;
  logic signed [COORD_W-1:0] sy_i;
  logic                    last_i;

  always_comb begin
    cx_sum = px_h + NUM_W'(center_x);
    cy_sum = py_h + NUM_W'(center_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else if (en) begin
      vi <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_i   <= cx_sum[NUM_W-1:FRAC_BITS];
      sy_i   <= cy_sum[NUM_W-1:FRAC_BITS];
      last_i <= last_h;
    end
  end

  // Stage J: bounds check and row offset
  logic               in_x;
  logic               in_y;
  logic [24:0]        row_full;
  logic               vj;
  logic               inside_j;
  logic [INDEX_W-1:0] row_j;
  logic [PIX_W-1:0]   col_j;
  logic               last_j;

  always_comb begin
    in_x     = !sx_i[COORD_W-1] && (sx_i < $signed({{(COORD_W-SIDE_W){1'b0}}, source_width}));
    in_y     = !sy_i[COORD_W-1] && (sy_i < $signed({{(COORD_W-SIDE_W){1'b0}}, source_height}));
    row_full = {13'd0, sy_i[PIX_W-1:0]} * {12'd0, source_pitch};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vj <= 1'b0;
    end else if (en) begin
      vj <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_j <= in_x && in_y;
      row_j    <= row_full[INDEX_W-1:0];
      col_j    <= sx_i[PIX_W-1:0];
      last_j   <= last_i;
    end
  end

  // Stage K: final index, zero for points outside
  logic               vk;
  logic [INDEX_W-1:0] index_k;
  logic               inside_k;
  logic               last_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      vk <= 1'b0;
    end else if (en) begin
      vk <= vj;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_k  <= inside_j ? (row_j + INDEX_W'(col_j)) : '0;
      inside_k <= inside_j;
      last_k   <= last_j;
    end
  end

  // Output register with skid stage
  logic [INDEX_W-1:0] skid_index;
  logic               skid_inside;
  logic               skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= en && vk;
      end
    end else if (en && vk) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_index;
        m_tuser <= skid_inside;
        m_tlast <= skid_last;
      end else begin
        m_tdata <= index_k;
        m_tuser <= inside_k;
        m_tlast <= last_k;
      end
    end else if (en && vk) begin
      skid_index  <= index_k;
      skid_inside <= inside_k;
      skid_last   <= last_k;
    end
  end

endmodule

@@ design/rdsm_checker.sv @@
// Port-level checks for the radial distortion sample map.
// Depends only on the top level's ports; bound to it at the end of this file.
module rdsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Reset empties the output and opens the input
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output not empty or input closed after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Points outside the source give index zero
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("outside point with nonzero index");

  // Input only closes while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

endmodule

bind radial_distortion_sample_map rdsm_checker u_rdsm_checker (.*);
